// ----- sv/udph_pkg.sv -----
package udph_pkg;

	localparam logic [7:0]  VER_IHL     = 8'h45;
	localparam logic [7:0]  TTL_VALUE   = 8'd64;
	localparam logic [7:0]  PROTO_UDP   = 8'd17;
	localparam logic [16:0] HDR_LEN     = 17'd28;
	localparam logic [16:0] UDP_HDR_LEN = 17'd8;
	localparam logic [4:0]  LAST_OFFSET = 5'd27;
	localparam logic [15:0] MAX_LEN_RST = 16'd1500;
	localparam logic [15:0] COUNT_SAT   = 16'hFFFF;

	// header generator sequence
	typedef enum logic [2:0] {
		GEN_IDLE,
		GEN_LEN,
		GEN_SUM,
		GEN_FOLD,
		GEN_EMIT
	} gen_state_t;

	// datagram summary handed over on the last payload beat
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] count;
		logic [15:0] sum;
	} udph_req_t;

	// ones-complement fold of a sum of at most 20 bits
	function automatic logic [15:0] fold20(input logic [19:0] x);
		logic [16:0] s1;
		logic [16:0] s2;
		begin
			s1 = {1'b0, x[15:0]} + {13'd0, x[19:16]};
			s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
			return s2[15:0];
		end
	endfunction

endpackage

// ----- sv/udph_hdr_gen.sv -----
module udph_hdr_gen (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  udph_pkg::udph_req_t   req,
	input  logic [15:0]           max_len,
	output logic                  busy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            header_byte,
	output logic [4:0]            header_offset,
	output logic                  run_end,
	output logic                  too_long
);
	import udph_pkg::*;

	gen_state_t  state_q, state_d;
	udph_req_t   req_q;
	logic [15:0] total_q;
	logic [15:0] ulen_q;
	logic        too_long_q;
	logic [17:0] addr_sum_q;
	logic [19:0] ip_raw_q;
	logic [19:0] udp_raw_q;
	logic [15:0] hc_q;
	logic [15:0] uc_q;
	logic [4:0]  off_q;
	logic        done;

	logic [16:0] total_w;
	logic [16:0] ulen_w;

	assign total_w = HDR_LEN + {1'b0, req_q.count};
	assign ulen_w  = UDP_HDR_LEN + {1'b0, req_q.count};
	assign done    = too_long_q || (off_q == LAST_OFFSET);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			GEN_IDLE: begin
				if (req_valid) state_d = GEN_LEN;
			end
			GEN_LEN:  state_d = GEN_SUM;
			GEN_SUM:  state_d = GEN_FOLD;
			GEN_FOLD: state_d = GEN_EMIT;
			GEN_EMIT: begin
				if (out_ready && done) state_d = GEN_IDLE;
			end
			default:  state_d = GEN_IDLE;
		endcase
	end

	// length, sums, checksums and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else begin
			if (state_q == GEN_FOLD) begin
				off_q <= '0;
			end else if (state_q == GEN_EMIT && out_ready && !done) begin
				off_q <= off_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == GEN_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == GEN_LEN) begin
			total_q    <= total_w[15:0];
			ulen_q     <= ulen_w[15:0];
			too_long_q <= total_w > {1'b0, max_len};
			addr_sum_q <= {2'b0, req_q.src_addr[31:16]} + {2'b0, req_q.src_addr[15:0]}
				+ {2'b0, req_q.dst_addr[31:16]} + {2'b0, req_q.dst_addr[15:0]};
		end
		if (state_q == GEN_SUM) begin
			ip_raw_q  <= {4'd0, VER_IHL, 8'd0} + {4'd0, TTL_VALUE, PROTO_UDP}
				+ {4'd0, total_q} + {2'd0, addr_sum_q};
			udp_raw_q <= {2'd0, addr_sum_q} + {12'd0, PROTO_UDP}
				+ {3'd0, ulen_q, 1'b0} + {4'd0, req_q.src_port}
				+ {4'd0, req_q.dst_port} + {4'd0, req_q.sum};
		end
		if (state_q == GEN_FOLD) begin
			hc_q <= ~fold20(ip_raw_q);
			uc_q <= ~fold20(udp_raw_q);
		end
	end

	// header byte select
	always_comb begin
		header_byte = 8'd0;
		if (!too_long_q) begin
			case (off_q)
				5'd0:  header_byte = VER_IHL;
				5'd2:  header_byte = total_q[15:8];
				5'd3:  header_byte = total_q[7:0];
				5'd8:  header_byte = TTL_VALUE;
				5'd9:  header_byte = PROTO_UDP;
				5'd10: header_byte = hc_q[15:8];
				5'd11: header_byte = hc_q[7:0];
				5'd12: header_byte = req_q.src_addr[31:24];
				5'd13: header_byte = req_q.src_addr[23:16];
				5'd14: header_byte = req_q.src_addr[15:8];
				5'd15: header_byte = req_q.src_addr[7:0];
				5'd16: header_byte = req_q.dst_addr[31:24];
				5'd17: header_byte = req_q.dst_addr[23:16];
				5'd18: header_byte = req_q.dst_addr[15:8];
				5'd19: header_byte = req_q.dst_addr[7:0];
				5'd20: header_byte = req_q.src_port[15:8];
				5'd21: header_byte = req_q.src_port[7:0];
				5'd22: header_byte = req_q.dst_port[15:8];
				5'd23: header_byte = req_q.dst_port[7:0];
				5'd24: header_byte = ulen_q[15:8];
				5'd25: header_byte = ulen_q[7:0];
				5'd26: header_byte = uc_q[15:8];
				5'd27: header_byte = uc_q[7:0];
				default: header_byte = 8'd0;
			endcase
		end
	end

	// result beat
	assign busy          = (state_q != GEN_IDLE);
	assign out_valid     = (state_q == GEN_EMIT);
	assign header_offset = off_q;
	assign run_end       = done;
	assign too_long      = too_long_q;

endmodule

// ----- sv/ipv4_udp_header_builder_unit.sv -----
// Payload beats that are not the last are absorbed at one beat per cycle.
// A last beat starts the header: the generator passes its length, sum and fold states,
// then gives 28 header beats (or one error beat), one per cycle with no stall downstream.
// Payload of the next datagram is taken meanwhile; its last beat waits until
// the previous header has fully left the generator.
// Asynchronous reset clears the running sum and count and sets the maximum to 1500.
module ipv4_udp_header_builder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic        last_byte,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  header_byte,
	output logic [4:0]  header_offset,
	output logic        run_end,
	output logic        too_long
);
	import udph_pkg::*;

	logic [15:0] max_len_q;
	logic [15:0] sum_q;
	logic [15:0] count_q;
	logic [7:0]  held_q;
	logic        odd_q;

	logic        gen_busy;
	logic        accept;
	logic [15:0] word;
	logic [15:0] sum_next;
	logic [15:0] count_next;
	udph_req_t   req;

	// a last beat waits while a header is still in flight
	assign in_ready = !(gen_busy && last_byte);
	assign accept   = in_valid && in_ready;

	// word to add: a completed pair, or a lone high byte at the end
	assign word       = odd_q ? {held_q, payload_byte} : {payload_byte, 8'd0};
	assign sum_next   = fold20({4'd0, sum_q} + {4'd0, word});
	assign count_next = (count_q == COUNT_SAT) ? count_q : count_q + 16'd1;

	// maximum length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// running sum and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			held_q  <= '0;
			odd_q   <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				sum_q   <= '0;
				count_q <= '0;
				held_q  <= '0;
				odd_q   <= 1'b0;
			end else begin
				count_q <= count_next;
				if (odd_q) begin
					sum_q <= sum_next;
					odd_q <= 1'b0;
				end else begin
					held_q <= payload_byte;
					odd_q  <= 1'b1;
				end
			end
		end
	end

	// datagram summary for the header generator
	assign req.src_addr = source_address;
	assign req.dst_addr = dest_address;
	assign req.src_port = source_port;
	assign req.dst_port = dest_port;
	assign req.count    = count_next;
	assign req.sum      = sum_next;

	udph_hdr_gen u_hdr_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (accept && last_byte),
		.req           (req),
		.max_len       (max_len_q),
		.busy          (gen_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.header_byte   (header_byte),
		.header_offset (header_offset),
		.run_end       (run_end),
		.too_long      (too_long)
	);

endmodule

// ----- bench/ipv4_udp_header_builder_unit_tb.sv -----
module ipv4_udp_header_builder_unit_tb;
	import udph_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_BEATS = 16;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_COUNT, FILL_RANDOM, FILL_CSUM_ZERO} fill_t;

	typedef struct packed {
		logic [7:0] data;
		logic [4:0] offset;
		logic       fin;
		logic       err;
	} hdr_beat_t;

	localparam hdr_beat_t TOO_LONG_BEAT = '{data: 8'h00, offset: 5'd0, fin: 1'b1, err: 1'b1};

	// one datagram to send; new_max of zero keeps the current maximum
	typedef struct {
		logic [15:0] new_max;
		int unsigned len;
		fill_t       fill;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		bit          err_typed;
	} shot_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  payload_byte;
	logic        last_byte;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  header_byte;
	logic [4:0]  header_offset;
	logic        run_end;
	logic        too_long;

	// running datagram state mirrored from the block
	logic [31:0] word_sum;
	logic [15:0] bytes_taken;
	logic [7:0]  high_half;
	logic        half_held;
	logic [15:0] max_total;

	hdr_beat_t   hdr_pred [28];
	int unsigned hdr_pred_n;
	hdr_beat_t   hdr_due [$];

	int unsigned fault_count = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on = 1'b1;
	int unsigned gap_odds = 3;
	bit          hold_phase = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned rx_mode = 1;
	logic [5:0]  rx_tick = 6'd0;

	// directed datagrams: extremes, odd and even lengths, zero checksum, length limit
	shot_t plan [8] = '{
		'{16'd0,    1, FILL_ZERO,      32'h00000000, 32'h00000000, 16'h0000, 16'h0000, 1'b0},
		'{16'd0,    1, FILL_ONES,      32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
		'{16'd0,    2, FILL_CSUM_ZERO, 32'hC0A80001, 32'hC0A800FE, 16'h1234, 16'h0035, 1'b0},
		'{16'd0,    3, FILL_COUNT,     32'h0A000001, 32'h0A000002, 16'h8000, 16'h0001, 1'b0},
		'{16'd0,    4, FILL_ONES,      32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h8000, 1'b0},
		'{16'd29,   1, FILL_ONES,      32'h01020304, 32'h05060708, 16'h0400, 16'h0800, 1'b0},
		'{16'd0,    2, FILL_ZERO,      32'h11223344, 32'h55667788, 16'h0101, 16'h0202, 1'b1},
		'{16'd1500, 3, FILL_RANDOM,    32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555, 1'b0}
	};

	always #1 clk = ~clk;

	ipv4_udp_header_builder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.payload_byte   (payload_byte),
		.last_byte      (last_byte),
		.source_address (source_address),
		.dest_address   (dest_address),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.header_byte    (header_byte),
		.header_offset  (header_offset),
		.run_end        (run_end),
		.too_long       (too_long)
	);

	// end-around carry fold down to 16 bits
	function automatic logic [31:0] ones_fold(input logic [31:0] s);
		logic [31:0] r;
		r = s;
		while (r[31:16] != 16'd0)
			r = {16'd0, r[15:0]} + {16'd0, r[31:16]};
		return r;
	endfunction

	function automatic void clear_datagram();
		word_sum    = 32'd0;
		bytes_taken = 16'd0;
		high_half   = 8'd0;
		half_held   = 1'b0;
	endfunction

	// absorb one payload beat; on the last one, build the header or the length error
	function automatic void predict_header(input logic [7:0] pb, input logic lb,
			input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] sp, input logic [15:0] dp);
		logic [31:0] total;
		logic [31:0] ulen;
		logic [31:0] ip_acc;
		logic [31:0] udp_acc;
		logic [31:0] ip_csum;
		logic [31:0] udp_csum;
		logic [7:0]  hb [28];
		hdr_pred_n = 0;
		if (half_held) begin
			word_sum  = ones_fold(word_sum + {16'd0, high_half, pb});
			half_held = 1'b0;
		end else begin
			high_half = pb;
			half_held = 1'b1;
		end
		if (bytes_taken != COUNT_SAT)
			bytes_taken = bytes_taken + 16'd1;
		if (lb) begin
			// odd length: last byte is the high half of a zero-padded word
			if (half_held)
				word_sum = ones_fold(word_sum + {16'd0, high_half, 8'h00});
			total = HDR_LEN + bytes_taken;
			if (total > max_total) begin
				hdr_pred[0] = TOO_LONG_BEAT;
				hdr_pred_n  = 1;
			end else begin
				ulen    = UDP_HDR_LEN + bytes_taken;
				ip_acc  = {VER_IHL, 8'h00} + total + {TTL_VALUE, PROTO_UDP}
					+ src[31:16] + src[15:0] + dst[31:16] + dst[15:0];
				ip_csum = ~ones_fold(ip_acc);
				// pseudo-header, udp header and payload; a zero result stays zero
				udp_acc = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + PROTO_UDP
					+ ulen + sp + dp + ulen + word_sum;
				udp_csum = ~ones_fold(udp_acc);
				foreach (hb[k])
					hb[k] = 8'h00;
				hb[0] = VER_IHL;
				{hb[2], hb[3]} = total[15:0];
				hb[8] = TTL_VALUE;
				hb[9] = PROTO_UDP;
				{hb[10], hb[11]} = ip_csum[15:0];
				{hb[12], hb[13], hb[14], hb[15]} = src;
				{hb[16], hb[17], hb[18], hb[19]} = dst;
				{hb[20], hb[21]} = sp;
				{hb[22], hb[23]} = dp;
				{hb[24], hb[25]} = ulen[15:0];
				{hb[26], hb[27]} = udp_csum[15:0];
				for (int k = 0; k < HDR_LEN; k++)
					hdr_pred[k] = '{data: hb[k], offset: 5'(k), fin: (k == LAST_OFFSET), err: 1'b0};
				hdr_pred_n = HDR_LEN;
			end
			clear_datagram();
		end
	endfunction

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 7))
			0: return 32'h00000000;
			1: return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic shot_t random_shot();
		shot_t s;
		s.new_max   = 16'd0;
		s.len       = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 20);
		case ($urandom_range(0, 9))
			0: s.fill = FILL_ZERO;
			1: s.fill = FILL_ONES;
			default: s.fill = FILL_RANDOM;
		endcase
		s.src       = pick_addr();
		s.dst       = pick_addr();
		s.sport     = pick_port();
		s.dport     = pick_port();
		s.err_typed = 1'b0;
		return s;
	endfunction

	// present one payload beat and hold it until taken
	task automatic offer_beat(input logic [7:0] pb, input logic lb,
			input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] sp, input logic [15:0] dp);
		@(negedge clk);
		in_valid       <= 1'b1;
		payload_byte   <= pb;
		last_byte      <= lb;
		source_address <= src;
		dest_address   <= dst;
		source_port    <= sp;
		dest_port      <= dp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_datagram(input shot_t s);
		logic [31:0] rest;
		logic [15:0] csum_word;
		logic [7:0]  pb;
		logic [31:0] a_src;
		logic [31:0] a_dst;
		logic [15:0] a_sp;
		logic [15:0] a_dp;
		logic        lb;
		bit          calm;
		// payload word that brings the udp sum to all ones
		rest = s.src[31:16] + s.src[15:0] + s.dst[31:16] + s.dst[15:0] + PROTO_UDP
			+ 2 * (UDP_HDR_LEN + s.len) + s.sport + s.dport;
		rest = ones_fold(rest);
		csum_word = 16'hFFFF - rest[15:0];
		calm = ($urandom_range(0, 3) == 0);
		for (int unsigned k = 0; k < s.len; k++) begin
			case (s.fill)
				FILL_ZERO:      pb = 8'h00;
				FILL_ONES:      pb = 8'hFF;
				FILL_COUNT:     pb = k[7:0];
				FILL_CSUM_ZERO: pb = (k == 0) ? csum_word[15:8] : csum_word[7:0];
				default:        pb = 8'($urandom_range(0, 255));
			endcase
			lb = (k == s.len - 1);
			// header fields only count on the last beat; scramble them elsewhere
			if (lb) begin
				a_src = s.src;
				a_dst = s.dst;
				a_sp  = s.sport;
				a_dp  = s.dport;
			end else begin
				a_src = $urandom;
				a_dst = $urandom;
				a_sp  = 16'($urandom);
				a_dp  = 16'($urandom);
			end
			if (idle_on && !calm && $urandom_range(0, gap_odds) == 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 17)) @(negedge clk);
			end
			offer_beat(pb, lb, a_src, a_dst, a_sp, a_dp);
			predict_header(pb, lb, a_src, a_dst, a_sp, a_dp);
			if (hdr_pred_n != 0) begin
				if (s.err_typed)
					hdr_due.push_back(TOO_LONG_BEAT);
				else
					for (int unsigned j = 0; j < hdr_pred_n; j++)
						hdr_due.push_back(hdr_pred[j]);
			end
		end
	endtask

	// change the maximum only once every header has drained
	task automatic set_max(input logic [15:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (hdr_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		max_total = v;
	endtask

	// receiver: random stall bursts, calm windows, one long hold-off
	always @(negedge clk) begin
		if (rx_tick == 6'd0)
			rx_mode = $urandom_range(0, 2);
		rx_tick = rx_tick + 6'd1;
		if (hold_phase && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && rx_mode != 0
				&& $urandom_range(0, (rx_mode == 1) ? 3 : 12) == 0) begin
			stall_left = $urandom_range(0, 17);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each header beat with the oldest expectation
	always @(posedge clk) begin
		hdr_beat_t got;
		hdr_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{data: header_byte, offset: header_offset, fin: run_end, err: too_long};
			if (hdr_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected header beat: byte %02h offset %0d end %0b too_long %0b",
						got.data, got.offset, got.fin, got.err);
			end else begin
				want = hdr_due.pop_front();
				if (got.data !== want.data || got.offset !== want.offset
						|| got.fin !== want.fin || got.err !== want.err) begin
					fault_count++;
					if (fault_count <= 10)
						$display("header beat mismatch: expected %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b",
							want.data, want.offset, want.fin, want.err,
							got.data, got.offset, got.fin, got.err);
				end
			end
		end
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		shot_t       s;
		int unsigned phase_beats;
		logic [15:0] phase_max;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		payload_byte   = 8'h00;
		last_byte      = 1'b0;
		source_address = 32'd0;
		dest_address   = 32'd0;
		source_port    = 16'd0;
		dest_port      = 16'd0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = 16'd0;
		max_total      = MAX_LEN_RST;
		clear_datagram();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed datagrams
		foreach (plan[i]) begin
			if (plan[i].new_max != 16'd0)
				set_max(plan[i].new_max);
			send_datagram(plan[i]);
		end

		// random datagrams under several maxima; the last phase runs without idling
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: phase_max = 16'($urandom_range(36, 60));
				1: phase_max = 16'($urandom_range(29, 65535));
				2: phase_max = 16'hFFFF;
				default: phase_max = MAX_LEN_RST;
			endcase
			if (phase == 3)
				idle_on = 1'b0;
			set_max(phase_max);
			if (phase == 0)
				hold_phase = 1'b1;
			phase_beats = 0;
			while (phase_beats < PHASE_BEATS) begin
				s = random_shot();
				send_datagram(s);
				phase_beats += s.len;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (hdr_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/udph_pkg.sv
sv/udph_hdr_gen.sv
sv/ipv4_udp_header_builder_unit.sv
bench/ipv4_udp_header_builder_unit_tb.sv
